[hdl/x86d_pkg.sv]
// Package with types, opcode tables and decode helper functions for the 16-bit x86 decoder.
package x86d_pkg;

	localparam int AddrBitsDefault = 16;

	typedef struct packed {
		logic [15:0] instr_offset;
		logic [63:0] byte_window;
	} in_item_t;

	typedef struct packed {
		logic [15:0] written_value;
		logic [15:0] jump_target;
		logic [15:0] immediate;
		logic signed [15:0] displacement;
		logic [1:0] segment_index;
		logic [1:0] mod_field;
		logic [2:0] rm_field;
		logic [2:0] reg_field;
		logic [6:0] flag_bits;
		logic [2:0] operand_form;
		logic [6:0] mnemonic_code;
		logic [3:0] instr_length;
	} out_item_t;

	typedef enum logic [1:0] {
		EX_NONE = 2'd0,
		EX_IMM  = 2'd1,
		EX_REG  = 2'd2,
		EX_SEG  = 2'd3
	} exec_kind_t;

	// Decoded instruction plus execution request for the register stage.
	typedef struct packed {
		out_item_t  item;
		exec_kind_t exk;
		logic       word;
		logic       dir;
	} dec_t;

	localparam logic [6:0] MN_NONE = 7'd0, MN_POP = 7'd1, MN_PUSH = 7'd2, MN_DAA = 7'd3,
		MN_DAS = 7'd4, MN_AAA = 7'd5, MN_AAS = 7'd6, MN_ADD = 7'd7, MN_OR = 7'd8,
		MN_ADC = 7'd9, MN_SBB = 7'd10, MN_AND = 7'd11, MN_SUB = 7'd12, MN_XOR = 7'd13,
		MN_CMP = 7'd14, MN_INC = 7'd15, MN_DEC = 7'd16, MN_JO = 7'd17, MN_TEST = 7'd33,
		MN_XCHG = 7'd34, MN_MOV = 7'd35, MN_LEA = 7'd36, MN_CWD = 7'd37, MN_CBW = 7'd38,
		MN_CALL = 7'd39, MN_WAIT = 7'd40, MN_PUSHF = 7'd41, MN_LODS = 7'd45,
		MN_SCAS = 7'd46, MN_MOVS = 7'd47, MN_CMPS = 7'd48, MN_RET = 7'd49, MN_LDS = 7'd50,
		MN_LES = 7'd51, MN_RETF = 7'd52, MN_INT3 = 7'd53, MN_ROL = 7'd57, MN_SAR = 7'd63,
		MN_AAM = 7'd64,
		MN_AAD = 7'd65, MN_XLAT = 7'd66, MN_LOOPNZ = 7'd67, MN_OUT = 7'd71, MN_IN = 7'd72,
		MN_JMP = 7'd73, MN_STOS = 7'd74, MN_CMC = 7'd75, MN_HLT = 7'd76, MN_NOT = 7'd77,
		MN_CLC = 7'd83, MN_CALL_FAR = 7'd89, MN_JMP_FAR = 7'd90;

	localparam logic [7:0] OP_LOCK = 8'hF0;

	function automatic logic [7:0] at(input logic [63:0] w, input logic [3:0] k);
		logic [7:0] r;
		r = 8'h00;
		if (k < 4'd8) begin
			r = w[8*k[2:0] +: 8];
		end
		return r;
	endfunction

	function automatic logic [15:0] w16(input logic [63:0] w, input logic [3:0] k);
		return {at(w, k + 4'd1), at(w, k)};
	endfunction

	function automatic logic [15:0] sx8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	function automatic logic [6:0] string_mn(input logic [7:0] b);
		logic [6:0] r;
		if (b[3]) begin
			r = b[1] ? MN_SCAS : MN_LODS;
		end else begin
			r = b[1] ? MN_CMPS : MN_MOVS;
		end
		return r;
	endfunction

	function automatic logic [6:0] shf_mn(input logic [2:0] r);
		return (r == 3'd6) ? MN_NONE : (r == 3'd7 ? MN_SAR : MN_ROL + {4'd0, r});
	endfunction

	function automatic logic [6:0] una_mn(input logic [2:0] r);
		return (r == 3'd0) ? MN_TEST : (r == 3'd1 ? MN_NONE : MN_NOT + {4'd0, r} - 7'd2);
	endfunction

	function automatic logic [6:0] clr_mn(input logic [2:0] r);
		return (r > 3'd5) ? MN_NONE : MN_CLC + {4'd0, r};
	endfunction

	function automatic logic [6:0] ind_mn(input logic [2:0] r);
		logic [6:0] m;
		unique case (r)
			3'd0: m = MN_INC;
			3'd1: m = MN_DEC;
			3'd2: m = MN_CALL;
			3'd3: m = MN_CALL_FAR;
			3'd4: m = MN_JMP;
			3'd5: m = MN_JMP_FAR;
			3'd6: m = MN_PUSH;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] short_mn(input logic [1:0] r);
		logic [6:0] m;
		unique case (r)
			2'd0: m = MN_INC;
			2'd1: m = MN_DEC;
			2'd2: m = MN_PUSH;
			default: m = MN_POP;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] bcd_mn(input logic [1:0] r);
		return MN_DAA + {5'd0, r};
	endfunction

	function automatic logic [6:0] alu_mn(input logic [2:0] r);
		return MN_ADD + {4'd0, r};
	endfunction

endpackage

[hdl/x86d_decode.sv]
// Combinational instruction decoder: prefixes, opcode, modrm, displacement, immediate, target.
module x86d_decode import x86d_pkg::*; #(
	parameter int ADDRESS_BITS = AddrBitsDefault
) (
	input  in_item_t din,
	output dec_t     dout
);

	logic [63:0] w;
	logic [3:0]  p, len, q;
	logic [7:0]  b0, b1, bp;
	logic [6:0]  mn, flags;
	logic [2:0]  form, reg_f, rm_f;
	logic [1:0]  mod_f, seg, rel;
	logic        word, dir, rmuse, hasimm, immw, immsx, bad;
	logic [15:0] disp, imm, tgt, d;
	exec_kind_t  exk;
	logic [ADDRESS_BITS-1:0] tsum;

	always_comb begin
		w = din.byte_window;
		p = 4'd0; flags = 7'd0; seg = 2'd0; form = 3'd0; reg_f = 3'd0; rm_f = 3'd0;
		mod_f = 2'd0; dir = 1'b0; rel = 2'd0; exk = EX_NONE; rmuse = 1'b0; hasimm = 1'b0;
		immw = 1'b0; immsx = 1'b0; bad = 1'b0; disp = 16'd0; imm = 16'd0; tgt = 16'd0;
		mn = MN_NONE; d = 16'd0; tsum = '0;
		if (at(w, 4'd0) == OP_LOCK) begin
			flags[0] = 1'b1;
			p = 4'd1;
		end
		bp = at(w, p);
		if (bp == 8'h26 || bp == 8'h2E || bp == 8'h36 || bp == 8'h3E) begin
			flags[6] = 1'b1;
			seg = bp[4:3];
			p = p + 4'd1;
		end
		b0 = at(w, p);
		b1 = at(w, p + 4'd1);
		word = b0[0];
		len = p + 4'd1;

		if (b0 < 8'h40) begin
			if (b0[2:1] == 2'b11) begin
				if (b0 < 8'h20) begin
					mn = b0[0] ? MN_POP : MN_PUSH; form = 3'd6; seg = b0[4:3];
				end else if (b0[0]) begin
					mn = bcd_mn(b0[4:3]);
				end else begin
					bad = 1'b1;
				end
			end else begin
				mn = alu_mn(b0[5:3]);
				if (b0[2]) begin
					form = 3'd5; hasimm = 1'b1; immw = word;
				end else begin
					form = 3'd2; rmuse = 1'b1; dir = b0[1];
				end
			end
		end else if (b0 < 8'h60) begin
			mn = short_mn(b0[4:3]); form = 3'd7; reg_f = b0[2:0];
		end else if (b0 < 8'h70) begin
			bad = 1'b1;
		end else if (b0 < 8'h80) begin
			mn = MN_JO + {3'd0, b0[3:0]}; rel = 2'd1;
		end else if (b0 < 8'h84) begin
			mn = alu_mn(b1[5:3]); form = 3'd4; rmuse = 1'b1; hasimm = 1'b1;
			immw = word; immsx = b0[1];
		end else if (b0 < 8'h88) begin
			mn = (b0 < 8'h86) ? MN_TEST : MN_XCHG; form = 3'd2; rmuse = 1'b1;
			dir = flags[0] ? 1'b0 : b0[1];
		end else if (b0 < 8'h8C) begin
			mn = MN_MOV; form = 3'd2; rmuse = 1'b1; dir = b0[1]; exk = EX_REG;
		end else if (b0 == 8'h8C || b0 == 8'h8E) begin
			mn = MN_MOV; form = 3'd6; rmuse = 1'b1; word = 1'b1; dir = b0[1];
			exk = EX_SEG; seg = b1[4:3];
		end else if (b0 == 8'h8D) begin
			mn = MN_LEA; form = 3'd2; rmuse = 1'b1; dir = 1'b1;
		end else if (b0 == 8'h8F) begin
			mn = MN_POP; form = 3'd1; rmuse = 1'b1;
		end else if (b0 < 8'h98) begin
			mn = MN_XCHG; form = 3'd7; reg_f = b0[2:0];
		end else if (b0 == 8'h98) begin
			mn = MN_CBW;
		end else if (b0 == 8'h99) begin
			mn = MN_CWD;
		end else if (b0 == 8'h9A || b0 == 8'hEA) begin
			mn = (b0 == 8'h9A) ? MN_CALL_FAR : MN_JMP_FAR; form = 3'd3;
			disp = w16(w, p + 4'd1); imm = w16(w, p + 4'd3); len = p + 4'd5;
		end else if (b0 == 8'h9B) begin
			mn = MN_WAIT;
		end else if (b0 < 8'hA0) begin
			mn = MN_PUSHF + {5'd0, b0[1:0]};
		end else if (b0 < 8'hA4) begin
			mn = MN_MOV; form = 3'd2; rm_f = 3'd6; disp = w16(w, p + 4'd1);
			len = p + 4'd3; dir = ~b0[1];
		end else if (b0 < 8'hA8 || (b0 >= 8'hAC && b0 < 8'hB0)) begin
			mn = string_mn(b0);
		end else if (b0 < 8'hAA) begin
			mn = MN_TEST; form = 3'd5; hasimm = 1'b1; immw = word;
		end else if (b0 < 8'hB0) begin
			bad = 1'b1;
		end else if (b0 < 8'hC0) begin
			mn = MN_MOV; form = 3'd7; reg_f = b0[2:0]; word = b0[3]; dir = 1'b1;
			hasimm = 1'b1; immw = b0[3]; exk = EX_IMM;
		end else if (b0 == 8'hC2 || b0 == 8'hCA) begin
			mn = (b0 == 8'hC2) ? MN_RET : MN_RETF; form = 3'd3; hasimm = 1'b1; immw = 1'b1;
		end else if (b0 == 8'hC3) begin
			mn = MN_RET;
		end else if (b0 == 8'hCB) begin
			mn = MN_RETF;
		end else if (b0 == 8'hC4 || b0 == 8'hC5) begin
			mn = b0[0] ? MN_LDS : MN_LES; form = 3'd2; rmuse = 1'b1; word = 1'b1; dir = 1'b1;
		end else if (b0 == 8'hC6 || b0 == 8'hC7) begin
			mn = MN_MOV; form = 3'd4; rmuse = 1'b1; hasimm = 1'b1; immw = word;
		end else if (b0 >= 8'hCC && b0 < 8'hD0) begin
			mn = MN_INT3 + {5'd0, b0[1:0]};
			if (b0 == 8'hCD) begin
				form = 3'd3; hasimm = 1'b1;
			end
		end else if (b0 >= 8'hD0 && b0 < 8'hD4) begin
			mn = shf_mn(b1[5:3]); form = 3'd1; rmuse = 1'b1; flags[3] = b0[1];
		end else if (b0 == 8'hD4 || b0 == 8'hD5) begin
			mn = b0[0] ? MN_AAD : MN_AAM; len = p + 4'd2;
		end else if (b0 == 8'hD7) begin
			mn = MN_XLAT;
		end else if (b0 >= 8'hE0 && b0 < 8'hE4) begin
			mn = MN_LOOPNZ + {5'd0, b0[1:0]}; rel = 2'd1;
		end else if (b0 >= 8'hE4 && b0 < 8'hE8) begin
			mn = b0[1] ? MN_OUT : MN_IN; form = 3'd5; hasimm = 1'b1; dir = ~b0[1];
		end else if (b0 == 8'hE8 || b0 == 8'hE9) begin
			mn = b0[0] ? MN_JMP : MN_CALL; rel = 2'd2;
		end else if (b0 == 8'hEB) begin
			mn = MN_JMP; rel = 2'd1;
		end else if (b0 >= 8'hEC && b0 < 8'hF0) begin
			mn = b0[1] ? MN_OUT : MN_IN; dir = ~b0[1];
		end else if (b0 == 8'hF3) begin
			mn = (b1[7:1] == 7'h55) ? MN_STOS : string_mn(b1);
			word = b1[0]; len = p + 4'd2;
		end else if (b0 == 8'hF4 || b0 == 8'hF5) begin
			mn = b0[0] ? MN_CMC : MN_HLT;
		end else if (b0 == 8'hF6 || b0 == 8'hF7) begin
			mn = una_mn(b1[5:3]); rmuse = 1'b1;
			if (b1[5:3] == 3'd0) begin
				form = 3'd4; hasimm = 1'b1; immw = word;
			end else begin
				form = 3'd1;
			end
		end else if (b0 >= 8'hF8 && b0 < 8'hFE) begin
			mn = clr_mn(b0[2:0]);
		end else if (b0 >= 8'hFE) begin
			mn = ind_mn(b1[5:3]); form = 3'd1; rmuse = 1'b1;
		end else begin
			bad = 1'b1;
		end

		q = p + 4'd1;
		if (rmuse) begin
			mod_f = b1[7:6]; rm_f = b1[2:0]; reg_f = b1[5:3]; q = p + 4'd2;
			if ((mod_f == 2'd0 && rm_f == 3'd6) || mod_f == 2'd2) begin
				disp = w16(w, q); q = q + 4'd2;
			end else if (mod_f == 2'd1) begin
				disp = sx8(at(w, q)); q = q + 4'd1;
			end
		end
		if (hasimm) begin
			if (immw && immsx) begin
				imm = sx8(at(w, q)); q = q + 4'd1;
			end else if (immw) begin
				imm = w16(w, q); q = q + 4'd2;
			end else begin
				imm = {8'd0, at(w, q)}; q = q + 4'd1;
			end
		end
		if (rmuse || hasimm) begin
			len = q;
		end
		if (rel != 2'd0) begin
			d = (rel == 2'd1) ? sx8(at(w, p + 4'd1)) : w16(w, p + 4'd1);
			len = p + 4'd1 + {2'd0, rel};
			tsum = ADDRESS_BITS'(din.instr_offset) + ADDRESS_BITS'(len)
				+ ADDRESS_BITS'({{(ADDRESS_BITS-16){d[15]}}, d});
			tgt = tsum[15:0];
			flags[1] = 1'b1;
		end
		if (bad) begin
			mn = MN_NONE; form = 3'd0; reg_f = 3'd0; word = 1'b0; dir = 1'b0;
			len = p + 4'd1; exk = EX_NONE;
		end
		flags[2] = (mn == MN_NONE);
		flags[4] = word;
		flags[5] = dir;

		dout.item.instr_length  = len;
		dout.item.mnemonic_code = mn;
		dout.item.operand_form  = form;
		dout.item.flag_bits     = flags;
		dout.item.reg_field     = reg_f;
		dout.item.rm_field      = rm_f;
		dout.item.mod_field     = mod_f;
		dout.item.segment_index = seg;
		dout.item.displacement  = disp;
		dout.item.immediate     = imm;
		dout.item.jump_target   = tgt;
		dout.item.written_value = 16'd0;
		dout.exk  = (exk == EX_IMM || mod_f == 2'd3) ? exk : EX_NONE;
		dout.word = word;
		dout.dir  = dir;
	end

endmodule

[hdl/x86_16bit_instruction_decode_exec.sv]
// Top level: decode stage, register-file execute stage and output register.
// One instruction is decoded in each cycle unless the input stalls: a transfer in is decoded
// combinationally and registered in stage 1, and its register mov (if any, and if enabled by
// cfg_data) is applied in stage 1 against the general and segment register files, which are
// read combinationally and written at the end of that cycle, so the next instruction already
// sees the write and a new instruction can follow every cycle while in_stall is low. A result
// goes from stage 1 into the output register. The output register and a one-entry skid absorb
// results while the receiver stalls; the input stalls while the skid holds a result or is about
// to take one. Register files reset to zero and need no clearing pass.
module x86_16bit_instruction_decode_exec import x86d_pkg::*; #(
	parameter int ADDRESS_BITS = AddrBitsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	dec_t        dec, dec_s1;
	logic        v_s1, en_q;
	logic [15:0] gpr_q [8];
	logic [15:0] sreg_q [4];
	out_item_t   res, out_q, skid_q;
	logic        ov_q, skid_v_q, adv;
	logic [15:0] wv, s, v, sv;
	logic [2:0]  de, se;

	x86d_decode #(.ADDRESS_BITS(ADDRESS_BITS)) u_dec (.din(in_data), .dout(dec));

	assign in_stall  = skid_v_q || (v_s1 && ov_q && out_stall);
	assign cfg_ready = 1'b1;
	assign adv       = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_valid) begin
			en_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= dec;
		end
	end

	always_comb begin
		res = dec_s1.item;
		wv = 16'd0; s = 16'd0; v = 16'd0; sv = 16'd0;
		de = dec_s1.dir ? dec_s1.item.reg_field : dec_s1.item.rm_field;
		se = dec_s1.dir ? dec_s1.item.rm_field : dec_s1.item.reg_field;
		if (en_q) begin
			case (dec_s1.exk)
				EX_IMM: begin
					if (dec_s1.word) begin
						wv = dec_s1.item.immediate;
					end else begin
						v = gpr_q[{1'b0, dec_s1.item.reg_field[1:0]}];
						wv = dec_s1.item.reg_field[2]
							? {dec_s1.item.immediate[7:0], v[7:0]}
							: {v[15:8], dec_s1.item.immediate[7:0]};
					end
				end
				EX_REG: begin
					if (dec_s1.word) begin
						wv = gpr_q[se];
					end else begin
						s = gpr_q[{1'b0, se[1:0]}];
						sv = se[2] ? {8'd0, s[15:8]} : {8'd0, s[7:0]};
						v = gpr_q[{1'b0, de[1:0]}];
						wv = de[2] ? {sv[7:0], v[7:0]} : {v[15:8], sv[7:0]};
					end
				end
				EX_SEG: begin
					wv = dec_s1.dir ? gpr_q[dec_s1.item.rm_field]
						: sreg_q[dec_s1.item.segment_index];
				end
				default: wv = 16'd0;
			endcase
		end
		res.written_value = wv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				gpr_q[i] <= 16'd0;
			end
			for (int i = 0; i < 4; i++) begin
				sreg_q[i] <= 16'd0;
			end
		end else if (v_s1 && en_q) begin
			case (dec_s1.exk)
				EX_IMM: begin
					if (dec_s1.word) begin
						gpr_q[dec_s1.item.reg_field] <= wv;
					end else begin
						gpr_q[{1'b0, dec_s1.item.reg_field[1:0]}] <= wv;
					end
				end
				EX_REG: begin
					if (dec_s1.word) begin
						gpr_q[de] <= wv;
					end else begin
						gpr_q[{1'b0, de[1:0]}] <= wv;
					end
				end
				EX_SEG: begin
					if (dec_s1.dir) begin
						sreg_q[dec_s1.item.segment_index] <= wv;
					end else begin
						gpr_q[dec_s1.item.rm_field] <= wv;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register with a skid entry; stage 1 always drains into one of them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!ov_q || !out_stall) begin
				if (skid_v_q) begin
					ov_q <= 1'b1;
					skid_v_q <= v_s1;
				end else begin
					ov_q <= v_s1;
				end
			end else if (v_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || !out_stall) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (v_s1) begin
					skid_q <= res;
				end
			end else begin
				out_q <= res;
			end
		end else if (v_s1) begin
			skid_q <= res;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule

[hdl/x86d_checker.sv]
// Port-level checker for the decoder top level, attached by bind.
module x86d_checker import x86d_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.instr_length >= 4'd1 && out_data.instr_length <= 4'd8)
		else $error("length out of range");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.flag_bits[2] == (out_data.mnemonic_code == MN_NONE))
		else $error("undecodable flag mismatch");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall |=> ##1 out_valid)
		else $error("result missing");

endmodule

bind x86_16bit_instruction_decode_exec x86d_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
